>>> design/masked_min_max_normalizer_defines.svh
// Assertion macros for the masked min/max normaliser.
`ifndef MASKED_MIN_MAX_NORMALIZER_DEFINES_SVH
`define MASKED_MIN_MAX_NORMALIZER_DEFINES_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> design/mmn_pkg.sv
// Shared types and constants for the masked min/max normaliser.
`timescale 1ns / 1ps
`default_nettype none

package mmn_pkg;

    localparam int SMP_W      = 40;
    localparam int OUT_W      = 20;
    localparam int FRAC_W     = 16;
    localparam int QBITS      = OUT_W + 1;
    localparam int DIVD_W     = SMP_W + FRAC_W + 1;
    localparam int REM_W      = SMP_W + 1;
    localparam int CNT_W      = $clog2(QBITS);
    localparam int CFG_ADDR_W = 2;

    localparam logic signed [SMP_W-1:0] SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
    localparam logic signed [SMP_W-1:0] SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};

    localparam logic signed [SMP_W-1:0] MARKER_RST    = 40'hFE1DC00000;
    localparam logic signed [SMP_W-1:0] FIXED_MAX_RST = 40'sd65536;

    localparam logic signed [OUT_W-1:0] OUT_MAX     = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN     = {1'b1, {(OUT_W-1){1'b0}}};
    localparam logic signed [OUT_W-1:0] RES_INVALID = 20'hF0000;
    localparam logic signed [OUT_W-1:0] RES_ZERO    = '0;

    localparam logic FUNC_GATHER = 1'b0;
    localparam logic FUNC_NORM   = 1'b1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_INVALID_MARKER = 2'd0,
        CFG_USE_FIXED_MAX  = 2'd1,
        CFG_FIXED_MAX      = 2'd2
    } cfg_addr_t;

    typedef struct packed {
        logic                    func;
        logic                    first;
        logic signed [SMP_W-1:0] sample;
    } item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] normalized;
        logic                    is_valid;
        logic                    degenerate;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_OUT
    } mmn_state_t;

    typedef enum logic [2:0] {
        DV_IDLE,
        DV_ABS,
        DV_LOAD,
        DV_CHECK,
        DV_STEP,
        DV_DONE
    } div_state_t;

endpackage

`default_nettype wire

>>> design/mmn_div.sv
// Bit-serial rounding divider with saturation to the Q3.16 result range.
`timescale 1ns / 1ps
`default_nettype none

module mmn_div (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic signed [mmn_pkg::SMP_W:0]  num,
    input  wire logic [mmn_pkg::SMP_W-1:0]       den,
    output logic                                 done,
    output logic signed [mmn_pkg::OUT_W-1:0]     quot
);
    import mmn_pkg::*;

    localparam logic [QBITS-1:0] QNEG_LIM = QBITS'(1) << (OUT_W - 1);

    div_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic signed [SMP_W:0] num_reg, num_next;
    logic [SMP_W-1:0]   den_reg, den_next;
    logic [SMP_W-1:0]   mag_reg, mag_next;
    logic               neg_reg, neg_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [QBITS-1:0]   lo_reg, lo_next;
    logic [QBITS-1:0]   q_reg, q_next;
    logic               ovf_reg, ovf_next;

    logic [DIVD_W-1:0]  divd;
    logic [REM_W-1:0]   den_ext;
    logic [REM_W-1:0]   trial;
    logic               trial_ge;
    logic [SMP_W:0]     num_abs;

    assign den_ext  = {1'b0, den_reg};
    assign trial    = {rem_reg[REM_W-2:0], lo_reg[QBITS-1]};
    assign trial_ge = (trial >= den_ext);
    assign num_abs  = num_reg[SMP_W] ? (~num_reg + 1'b1) : num_reg;
    assign divd     = {1'b0, mag_reg, {FRAC_W{1'b0}}} + DIVD_W'(den_reg >> 1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            DV_IDLE:  if (start) state_next = DV_ABS;
            DV_ABS:   state_next = DV_LOAD;
            DV_LOAD:  state_next = DV_CHECK;
            DV_CHECK: state_next = DV_STEP;
            DV_STEP:  if (cnt_reg == CNT_W'(QBITS - 1)) state_next = DV_DONE;
            DV_DONE:  state_next = DV_IDLE;
            default:  state_next = DV_IDLE;
        endcase
    end

    always_comb
    begin
        done = 1'b0;
        case (state_reg)
            DV_DONE: done = 1'b1;
            default: done = 1'b0;
        endcase
    end

    always_comb
    begin
        num_next = num_reg;
        den_next = den_reg;
        mag_next = mag_reg;
        neg_next = neg_reg;
        rem_next = rem_reg;
        lo_next  = lo_reg;
        q_next   = q_reg;
        ovf_next = ovf_reg;
        cnt_next = cnt_reg;
        case (state_reg)
            DV_IDLE:
            begin
                num_next = num;
                den_next = den;
            end
            DV_ABS:
            begin
                neg_next = num_reg[SMP_W];
                mag_next = num_abs[SMP_W-1:0];
            end
            DV_LOAD:
            begin
                rem_next = REM_W'(divd[DIVD_W-1:QBITS]);
                lo_next  = divd[QBITS-1:0];
            end
            DV_CHECK:
            begin
                ovf_next = (rem_reg >= den_ext);
                q_next   = '0;
                cnt_next = '0;
            end
            DV_STEP:
            begin
                rem_next = trial_ge ? (trial - den_ext) : trial;
                lo_next  = {lo_reg[QBITS-2:0], 1'b0};
                q_next   = {q_reg[QBITS-2:0], trial_ge};
                cnt_next = cnt_reg + 1'b1;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // saturate: magnitude limit is one larger on the negative side
    always_comb
    begin
        if (neg_reg)
        begin
            if (ovf_reg || (q_reg > QNEG_LIM))
                quot = OUT_MIN;
            else
                quot = OUT_W'(~q_reg[OUT_W-1:0] + 1'b1);
        end
        else
        begin
            if (ovf_reg || (q_reg >= QNEG_LIM))
                quot = OUT_MAX;
            else
                quot = q_reg[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
    end

endmodule

`default_nettype wire

>>> design/masked_min_max_normalizer.sv
// Top level of the masked min/max normaliser.
//
//  channel  | signals                          | carries
//  ---------+----------------------------------+-------------------------------
//  item     | item_valid, item_ready, item     | func, first, sample
//  result   | result_valid, result_ready,      | normalized, is_valid,
//           | result                           | degenerate
//  cfg      | cfg_we, cfg_addr, cfg_wdata      | register writes, no wait
//
// Gather item: capture, then statistics update. Normalize item with division:
// sign, load and range-check steps, then one quotient bit a cycle for 21 bits
// in the bit-serial divider, then hand-over. Invalid or degenerate normalize:
// goes to the output register without the divider.
// Reset restores state, configuration registers and statistics at once; no clearing pass.
// A finished result waits in the output register while the next item is taken;
// a further result waits until that register is read.
`timescale 1ns / 1ps
`default_nettype none
`include "masked_min_max_normalizer_defines.svh"

module masked_min_max_normalizer (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               item_valid,
    output logic                                    item_ready,
    input  wire mmn_pkg::item_t                     item,
    output logic                                    result_valid,
    input  wire logic                               result_ready,
    output mmn_pkg::result_t                        result,
    input  wire logic                               cfg_we,
    input  wire logic [mmn_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [mmn_pkg::SMP_W-1:0]          cfg_wdata
);
    import mmn_pkg::*;

    mmn_state_t            state_reg, state_next;
    item_t                 item_reg;
    result_t               pend_reg, pend_next;
    result_t               result_reg;
    logic                  result_valid_reg, result_valid_next;
    logic signed [SMP_W-1:0] marker_reg;
    logic                  use_fixed_reg;
    logic signed [SMP_W-1:0] fixed_max_reg;
    logic signed [SMP_W-1:0] min_reg, min_next;
    logic signed [SMP_W-1:0] max_reg, max_next;
    logic                  seen_reg, seen_next;

    logic                  item_take;
    logic                  div_start;
    logic                  div_done;
    logic signed [OUT_W-1:0] div_quot;
    logic                  out_load;

    logic signed [SMP_W-1:0] smp;
    logic                  smp_ok;
    logic signed [SMP_W-1:0] hi;
    logic                  degen;
    logic signed [SMP_W:0] num;
    logic signed [SMP_W:0] den_full;
    logic signed [SMP_W-1:0] base_min, base_max;
    logic                  base_seen;

    assign smp      = $signed(item_reg.sample);
    assign smp_ok   = (smp != marker_reg);
    assign hi       = use_fixed_reg ? fixed_max_reg : max_reg;
    assign degen    = !seen_reg || (hi <= min_reg);
    assign num      = {smp[SMP_W-1], smp} - {min_reg[SMP_W-1], min_reg};
    assign den_full = {hi[SMP_W-1], hi} - {min_reg[SMP_W-1], min_reg};

    assign item_take    = item_valid && item_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    mmn_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num),
        .den   (den_full[SMP_W-1:0]),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (item_take) state_next = ST_EXEC;
            ST_EXEC:
            begin
                if (item_reg.func == FUNC_GATHER)
                    state_next = ST_IDLE;
                else if (smp_ok && !degen)
                    state_next = ST_DIV;
                else
                    state_next = ST_OUT;
            end
            ST_DIV:  if (div_done) state_next = ST_OUT;
            ST_OUT:  if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        item_ready = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: item_ready = 1'b1;
            ST_EXEC: div_start  = (item_reg.func == FUNC_NORM) && smp_ok && !degen;
            ST_OUT:  out_load   = !result_valid_reg || result_ready;
            default: item_ready = 1'b0;
        endcase
    end

    // statistics update on gather
    always_comb
    begin
        base_min  = item_reg.first ? SMP_MAX : min_reg;
        base_max  = item_reg.first ? SMP_MIN : max_reg;
        base_seen = item_reg.first ? 1'b0 : seen_reg;
        min_next  = min_reg;
        max_next  = max_reg;
        seen_next = seen_reg;
        if (state_reg == ST_EXEC && item_reg.func == FUNC_GATHER)
        begin
            min_next  = (smp_ok && smp < base_min) ? smp : base_min;
            max_next  = (smp_ok && smp > base_max) ? smp : base_max;
            seen_next = base_seen || smp_ok;
        end
    end

    always_comb
    begin
        pend_next = pend_reg;
        case (state_reg)
            ST_EXEC:
            begin
                pend_next.is_valid   = smp_ok;
                pend_next.degenerate = degen;
                pend_next.normalized = smp_ok ? RES_ZERO : RES_INVALID;
            end
            ST_DIV:
            begin
                if (div_done)
                    pend_next.normalized = div_quot;
            end
            default: pend_next = pend_reg;
        endcase
    end

    always_comb
    begin
        if (out_load)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
            marker_reg       <= MARKER_RST;
            use_fixed_reg    <= 1'b0;
            fixed_max_reg    <= FIXED_MAX_RST;
            min_reg          <= SMP_MAX;
            max_reg          <= SMP_MIN;
            seen_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            min_reg          <= min_next;
            max_reg          <= max_next;
            seen_reg         <= seen_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_INVALID_MARKER: marker_reg    <= $signed(cfg_wdata);
                    CFG_USE_FIXED_MAX:  use_fixed_reg <= cfg_wdata[0];
                    CFG_FIXED_MAX:      fixed_max_reg <= $signed(cfg_wdata);
                    default:            use_fixed_reg <= use_fixed_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
            item_reg <= item;
        pend_reg <= pend_next;
        if (out_load)
            result_reg <= pend_reg;
    end

    `ASSERT_IMPLY(a_div_only_norm, clk, rst_n, state_reg == ST_DIV, item_reg.func == FUNC_NORM && pend_reg.is_valid && !pend_reg.degenerate)
    `ASSERT_NEXT(a_gather_short, clk, rst_n, state_reg == ST_EXEC && item_reg.func == FUNC_GATHER, state_reg == ST_IDLE)
    `ASSERT_IMPLY(a_stats_clear, clk, rst_n, !seen_reg, min_reg == SMP_MAX && max_reg == SMP_MIN)
    `ASSERT_IMPLY(a_stats_order, clk, rst_n, seen_reg, min_reg <= max_reg)

endmodule

`default_nettype wire
